/* sv/sprt_pkg.sv */
package sprt_pkg;

    localparam int SPR_SLOTS = 64;
    localparam int TB_TICKS  = 4;

    localparam int SLOT_W = $clog2(SPR_SLOTS);
    localparam int TB_PW  = (TB_TICKS > 1) ? $clog2(TB_TICKS) : 1;

    localparam logic [SLOT_W-1:0] HID1_SLOT = SLOT_W'(36);

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] CFG_PVR     = 2'd0;
    localparam logic [1:0] CFG_DEC_DIV = 2'd1;
    localparam logic [1:0] CFG_PLL     = 2'd2;

    localparam logic [4:0] DEC_DIV_RESET = 5'd2;

    typedef enum logic [2:0] {
        K_PLAIN,
        K_DEC,
        K_TBL,
        K_TBU,
        K_TBL_R,
        K_TBU_R,
        K_PVR,
        K_NONE
    } t_spr_kind;

    typedef struct packed {
        t_spr_kind         kind;
        logic [SLOT_W-1:0] slot;
    } t_spr_dec;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  spr_number;
        logic [31:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_value;
        logic        unknown_spr;
        logic        dec_interrupt;
    } t_out_item;

    // one step for the timer unit, already qualified by the stage firing
    typedef struct packed {
        logic        tick;
        logic        dec_wr;
        logic        tbl_wr;
        logic        tbu_wr;
        logic [31:0] data;
    } t_tmr_req;

    typedef struct packed {
        logic [63:0] tb;
        logic [31:0] dec;
        logic        irq;
    } t_tmr_stat;

    function automatic t_spr_dec spr_decode(input logic [9:0] n);
        t_spr_dec d;
        d.kind = K_PLAIN;
        d.slot = '0;
        if (n >= 10'd528 && n <= 10'd543) begin
            d.slot = SLOT_W'(13) + SLOT_W'(n[3:0]);
        end else if (n >= 10'd976 && n <= 10'd982) begin
            d.slot = SLOT_W'(29) + SLOT_W'(n[2:0]);
        end else if (n >= 10'd272 && n <= 10'd275) begin
            d.slot = SLOT_W'(5) + SLOT_W'(n[1:0]);
        end else begin
            case (n)
                10'd8:    d.slot = SLOT_W'(0);
                10'd9:    d.slot = SLOT_W'(1);
                10'd1:    d.slot = SLOT_W'(2);
                10'd26:   d.slot = SLOT_W'(3);
                10'd27:   d.slot = SLOT_W'(4);
                10'd18:   d.slot = SLOT_W'(9);
                10'd19:   d.slot = SLOT_W'(10);
                10'd282:  d.slot = SLOT_W'(11);
                10'd25:   d.slot = SLOT_W'(12);
                10'd1009: d.slot = HID1_SLOT;
                10'd1008: d.slot = SLOT_W'(37);
                10'd1011: d.slot = SLOT_W'(38);
                10'd1010: d.slot = SLOT_W'(39);
                10'd22:   d.kind = K_DEC;
                10'd284:  d.kind = K_TBL;
                10'd285:  d.kind = K_TBU;
                10'd268:  d.kind = K_TBL_R;
                10'd269:  d.kind = K_TBU_R;
                10'd287:  d.kind = K_PVR;
                default:  d.kind = K_NONE;
            endcase
        end
        return d;
    endfunction

endpackage

/* sv/sprt_ram.sv */
module sprt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/sprt_timers.sv */
module sprt_timers (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sprt_pkg::t_tmr_req  i_req,
    input  logic [4:0]          i_divider,
    output sprt_pkg::t_tmr_stat o_stat
);

    import sprt_pkg::*;

    logic [63:0]      r_tb;
    logic [TB_PW-1:0] r_tb_pre;
    logic [31:0]      r_dec;
    logic [4:0]       r_dec_pre;

    logic [4:0]       div;
    logic             tb_step;
    logic             dec_step;

    // a zero divider counts as one
    assign div      = (i_divider == 5'd0) ? 5'd1 : i_divider;
    assign tb_step  = ({1'b0, r_tb_pre} + (TB_PW+1)'(1)) >= (TB_PW+1)'(TB_TICKS);
    assign dec_step = ({1'b0, r_dec_pre} + 6'd1) >= {1'b0, div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tb      <= '0;
            r_tb_pre  <= '0;
            r_dec     <= '0;
            r_dec_pre <= '0;
        end else begin
            if (i_req.tick) begin
                if (tb_step) begin
                    r_tb_pre <= '0;
                    r_tb     <= r_tb + 64'd1;
                end else begin
                    r_tb_pre <= r_tb_pre + TB_PW'(1);
                end
                if (dec_step) begin
                    r_dec_pre <= '0;
                    r_dec     <= r_dec - 32'd1;
                end else begin
                    r_dec_pre <= r_dec_pre + 5'd1;
                end
            end
            if (i_req.dec_wr) begin
                r_dec <= i_req.data;
            end
            if (i_req.tbl_wr) begin
                r_tb[31:0] <= i_req.data;
                r_tb_pre   <= '0;
            end
            if (i_req.tbu_wr) begin
                r_tb[63:32] <= i_req.data;
                r_tb_pre    <= '0;
            end
        end
    end

    always_comb begin
        o_stat.tb  = r_tb;
        o_stat.dec = r_dec;
        o_stat.irq = (i_req.tick && dec_step && (r_dec == 32'd0))
                  || (i_req.dec_wr && ((i_req.data[31] && !r_dec[31])
                                       || (i_req.data == 32'd0)));
    end

endmodule

/* sv/special_register_file_with_timers_unit.sv */
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+-------------------------------
// in        | to unit   | i_in_valid / o_in_stall   | i_in_data  (cmd, spr, value)
// out       | from unit | o_out_valid / i_out_stall | o_out_data (read, unk, irq)
// cfg       | to unit   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each item passes from transfer in through the registered read of the
// register store, then forms its result and steps the timers into the result
// register. Items overlap, so one item a cycle is sustained while out flows.
// Synchronous active-low reset clears control, timers and the store valid
// bits; HID1 bits 31..28 sit in a flop of their own. A stall on out holds the
// result register, then the read stage, then stalls in.
module special_register_file_with_timers_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sprt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sprt_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    import sprt_pkg::*;

    // configuration
    logic [31:0]          r_pvr;
    logic [4:0]           r_dec_div;
    logic [3:0]           r_hid1_pll;

    // store valid bits: an entry never written reads as zero
    logic [SPR_SLOTS-1:0] r_slot_vld;

    // read stage
    logic                 r_s1_valid;
    logic [1:0]           r_s1_cmd;
    t_spr_kind            r_s1_kind;
    logic                 r_s1_hit;
    logic                 r_s1_hid1;
    logic [31:0]          r_s1_wval;

    // result register
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 in_acc;
    logic                 s2_fire;
    logic                 cfg_acc;
    t_spr_dec             dec_in;
    logic                 ram_we;
    logic [31:0]          ram_q;
    t_tmr_req             tmr_req;
    t_tmr_stat            tmr_stat;
    t_out_item            n_out;

    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    // advance the read stage whenever the result register can take it
    assign s2_fire    = r_s1_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_s1_valid && !s2_fire;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign dec_in = spr_decode(i_in_data.spr_number);
    assign ram_we = in_acc && (i_in_data.cmd == CMD_WRITE) && (dec_in.kind == K_PLAIN);

    // store writes land at transfer, so any later read sees them
    sprt_ram #(
        .WIDTH (32),
        .DEPTH (SPR_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (dec_in.slot),
        .i_wdata (i_in_data.write_value),
        .i_re    (in_acc),
        .i_raddr (dec_in.slot),
        .o_rdata (ram_q)
    );

    always_comb begin
        tmr_req.tick   = s2_fire && (r_s1_cmd == CMD_TICK);
        tmr_req.dec_wr = s2_fire && (r_s1_cmd == CMD_WRITE) && (r_s1_kind == K_DEC);
        tmr_req.tbl_wr = s2_fire && (r_s1_cmd == CMD_WRITE)
                      && ((r_s1_kind == K_TBL) || (r_s1_kind == K_TBL_R));
        tmr_req.tbu_wr = s2_fire && (r_s1_cmd == CMD_WRITE)
                      && ((r_s1_kind == K_TBU) || (r_s1_kind == K_TBU_R));
        tmr_req.data   = r_s1_wval;
    end

    sprt_timers u_timers (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tmr_req),
        .i_divider (r_dec_div),
        .o_stat    (tmr_stat)
    );

    // form the result of the item in the read stage
    always_comb begin
        n_out.read_value    = '0;
        n_out.unknown_spr   = 1'b0;
        n_out.dec_interrupt = tmr_stat.irq;
        case (r_s1_cmd)
            CMD_WRITE: begin
                n_out.unknown_spr = (r_s1_kind == K_NONE);
            end
            CMD_READ: begin
                case (r_s1_kind)
                    K_PLAIN: begin
                        n_out.read_value = r_s1_hit ? ram_q : 32'd0;
                        if (r_s1_hid1) begin
                            n_out.read_value[31:28] = r_hid1_pll;
                        end
                    end
                    K_DEC:   n_out.read_value = tmr_stat.dec;
                    K_TBL:   n_out.read_value = tmr_stat.tb[31:0];
                    K_TBU:   n_out.read_value = tmr_stat.tb[63:32];
                    K_PVR:   n_out.read_value = r_pvr;
                    default: n_out.unknown_spr = 1'b1;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvr       <= '0;
            r_dec_div   <= DEC_DIV_RESET;
            r_hid1_pll  <= '0;
            r_slot_vld  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_acc) begin
                case (i_cfg_index)
                    CFG_PVR:     r_pvr      <= i_cfg_data;
                    CFG_DEC_DIV: r_dec_div  <= i_cfg_data[4:0];
                    CFG_PLL:     r_hid1_pll <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            if (ram_we) begin
                r_slot_vld[dec_in.slot] <= 1'b1;
                if (dec_in.slot == HID1_SLOT) begin
                    r_hid1_pll <= i_in_data.write_value[31:28];
                end
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: hold the read stage and result register while stalled
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd  <= i_in_data.cmd;
            r_s1_kind <= dec_in.kind;
            r_s1_hit  <= r_slot_vld[dec_in.slot];
            r_s1_hid1 <= (dec_in.slot == HID1_SLOT);
            r_s1_wval <= i_in_data.write_value;
        end
        if (s2_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* tb/special_register_file_with_timers_unit_tb.sv */
`timescale 1ns / 1ps

module special_register_file_with_timers_unit_tb;
    import sprt_pkg::*;

    // cmd 3 is not an operation: the unit must leave all state alone
    localparam logic [1:0] CMD_UNDEF = 2'd3;

    // SPR numbers as encoded in mtspr/mfspr
    localparam logic [9:0] SPR_XER    = 10'd1;
    localparam logic [9:0] SPR_LR     = 10'd8;
    localparam logic [9:0] SPR_CTR    = 10'd9;
    localparam logic [9:0] SPR_DSISR  = 10'd18;
    localparam logic [9:0] SPR_DAR    = 10'd19;
    localparam logic [9:0] SPR_DEC    = 10'd22;
    localparam logic [9:0] SPR_SDR1   = 10'd25;
    localparam logic [9:0] SPR_SAVE0  = 10'd26;
    localparam logic [9:0] SPR_SAVE1  = 10'd27;
    localparam logic [9:0] SPR_TBL_R  = 10'd268;
    localparam logic [9:0] SPR_TBU_R  = 10'd269;
    localparam logic [9:0] SPR_SCR0   = 10'd272;
    localparam logic [9:0] SPR_SCR3   = 10'd275;
    localparam logic [9:0] SPR_EAR    = 10'd282;
    localparam logic [9:0] SPR_TBL_W  = 10'd284;
    localparam logic [9:0] SPR_TBU_W  = 10'd285;
    localparam logic [9:0] SPR_PVR    = 10'd287;
    localparam logic [9:0] SPR_IBAT0U = 10'd528;
    localparam logic [9:0] SPR_DBAT3L = 10'd543;
    localparam logic [9:0] SPR_DMISS  = 10'd976;
    localparam logic [9:0] SPR_RPA    = 10'd982;
    localparam logic [9:0] SPR_HID0   = 10'd1008;
    localparam logic [9:0] SPR_HID1   = 10'd1009;
    localparam logic [9:0] SPR_IABR   = 10'd1010;
    localparam logic [9:0] SPR_HID2   = 10'd1011;
    localparam logic [9:0] SPR_NONE   = 10'd0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    // Shadow copy of the unit's architectural state
    logic [31:0] plain_regs [0:1023];
    logic [63:0] time_base;
    int unsigned tb_phase;
    logic [31:0] dec_count;
    int unsigned dec_phase;
    logic [31:0] pvr_value;
    logic [4:0]  dec_div;

    t_in_item  pending_ops[$];
    t_out_item expected_results[$];
    int        ops_queued = 0;
    int        results_seen = 0;
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;

    special_register_file_with_timers_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Registers that are plain storage with no side effects
    function automatic bit is_plain(logic [9:0] n);
        if (n >= SPR_IBAT0U && n <= SPR_DBAT3L) return 1'b1;
        if (n >= SPR_DMISS && n <= SPR_RPA) return 1'b1;
        if (n >= SPR_SCR0 && n <= SPR_SCR3) return 1'b1;
        case (n)
            SPR_XER, SPR_LR, SPR_CTR, SPR_DSISR, SPR_DAR, SPR_SDR1, SPR_SAVE0,
            SPR_SAVE1, SPR_EAR, SPR_HID0, SPR_HID1, SPR_IABR, SPR_HID2: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit is_known(logic [9:0] n);
        if (is_plain(n)) return 1'b1;
        case (n)
            SPR_DEC, SPR_TBL_R, SPR_TBU_R, SPR_TBL_W, SPR_TBU_W, SPR_PVR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Work out the result of one transfer and advance the shadow state
    function automatic t_out_item spr_unit_predict(t_in_item op);
        t_out_item   res;
        logic [31:0] v;
        int unsigned eff_div;
        res = '0;
        v = op.write_value;
        eff_div = (dec_div == 5'd0) ? 1 : dec_div;
        case (op.cmd)
            CMD_TICK: begin
                if (tb_phase + 1 >= TB_TICKS) begin
                    tb_phase = 0;
                    time_base = time_base + 64'd1;
                end else begin
                    tb_phase++;
                end
                if (dec_phase + 1 >= eff_div) begin
                    dec_phase = 0;
                    if (dec_count == 32'd0) res.dec_interrupt = 1'b1;
                    dec_count = dec_count - 32'd1;
                end else begin
                    dec_phase++;
                end
            end
            CMD_WRITE: begin
                if (is_plain(op.spr_number)) begin
                    plain_regs[op.spr_number] = v;
                end else begin
                    case (op.spr_number)
                        SPR_DEC: begin
                            // interrupt on a fresh sign bit or on a zero write
                            if ((v[31] && !dec_count[31]) || v == 32'd0)
                                res.dec_interrupt = 1'b1;
                            dec_count = v;
                        end
                        SPR_TBL_W, SPR_TBL_R: begin
                            time_base[31:0] = v;
                            tb_phase = 0;
                        end
                        SPR_TBU_W, SPR_TBU_R: begin
                            time_base[63:32] = v;
                            tb_phase = 0;
                        end
                        SPR_PVR: ;
                        default: res.unknown_spr = 1'b1;
                    endcase
                end
            end
            CMD_READ: begin
                if (is_plain(op.spr_number)) begin
                    res.read_value = plain_regs[op.spr_number];
                end else begin
                    case (op.spr_number)
                        SPR_DEC:   res.read_value = dec_count;
                        SPR_TBL_W: res.read_value = time_base[31:0];
                        SPR_TBU_W: res.read_value = time_base[63:32];
                        SPR_PVR:   res.read_value = pvr_value;
                        default:   res.unknown_spr = 1'b1;
                    endcase
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Driver: present queued operations, predict each one as it transfers
    always @(posedge i_clk) begin : drive_ops
        t_in_item next_op;
        logic     next_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            next_op = i_in_data;
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(spr_unit_predict(i_in_data));
                next_valid = 1'b0;
            end
            // hold a stalled payload; load the next one only once the slot is free
            if (!next_valid && pending_ops.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                next_valid = 1'b1;
                next_op = pending_ops.pop_front();
            end
            i_in_valid <= next_valid;
            i_in_data <= next_op;
        end
    end

    // Monitor: check every result transfer against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unrequested result", o_out_data.read_value, 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.read_value !== want.read_value)
                        report_mismatch("read_value", o_out_data.read_value,
                                        want.read_value);
                    if (o_out_data.unknown_spr !== want.unknown_spr)
                        report_mismatch("unknown_spr", 32'(o_out_data.unknown_spr),
                                        32'(want.unknown_spr));
                    if (o_out_data.dec_interrupt !== want.dec_interrupt)
                        report_mismatch("dec_interrupt", 32'(o_out_data.dec_interrupt),
                                        32'(want.dec_interrupt));
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic queue_op(logic [1:0] cmd, logic [9:0] spr, logic [31:0] value);
        t_in_item op;
        op.cmd = cmd;
        op.spr_number = spr;
        op.write_value = value;
        pending_ops.push_back(op);
        ops_queued++;
    endtask

    // Pause the sender until every queued operation has produced its result
    task automatic wait_drained();
        while (results_seen < ops_queued) @(posedge i_clk);
    endtask

    // Configuration writes go in only while the unit is idle
    task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PVR:     pvr_value = data;
            CFG_DEC_DIV: dec_div = data[4:0];
            CFG_PLL:     plain_regs[SPR_HID1][31:28] = data[3:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] pvr, logic [4:0] div, logic [3:0] pll);
        wait_drained();
        // every operation yields a result, so once all results are seen nothing
        // can still be in flight; allow a little more
        repeat (4) @(posedge i_clk);
        write_cfg(CFG_PVR, pvr);
        write_cfg(CFG_DEC_DIV, 32'(div));
        write_cfg(CFG_PLL, 32'(pll));
    endtask

    // Load the decrementer with a small count and tick it through zero
    task automatic queue_dec_run();
        int unsigned v;
        int unsigned eff_div;
        v = $urandom_range(1, 2);
        eff_div = (dec_div == 5'd0) ? 1 : dec_div;
        queue_op(CMD_WRITE, SPR_DEC, 32'(v));
        repeat ((v + 2) * eff_div) queue_op(CMD_TICK, 10'($urandom), $urandom);
        queue_op(CMD_READ, SPR_DEC, $urandom);
    endtask

    // Force a carry from the low timebase half into the high half
    task automatic queue_tb_carry();
        queue_op(CMD_WRITE, $urandom_range(1) ? SPR_TBL_W : SPR_TBL_R, 32'hFFFF_FFFF);
        queue_op(CMD_WRITE, $urandom_range(1) ? SPR_TBU_W : SPR_TBU_R, $urandom);
        repeat (TB_TICKS) queue_op(CMD_TICK, 10'($urandom), $urandom);
        queue_op(CMD_READ, SPR_TBL_W, $urandom);
        queue_op(CMD_READ, SPR_TBU_W, $urandom);
    endtask

    function automatic logic [9:0] pick_spr();
        int unsigned r;
        logic [9:0]  n;
        r = $urandom_range(99);
        if (r < 15) return SPR_DEC;
        if (r < 25) begin
            case ($urandom_range(3))
                0: return SPR_TBL_W;
                1: return SPR_TBU_W;
                2: return SPR_TBL_R;
                default: return SPR_TBU_R;
            endcase
        end
        if (r < 30) return SPR_PVR;
        if (r < 85) begin
            do n = 10'($urandom); while (!is_known(n));
            return n;
        end
        return 10'($urandom);
    endfunction

    function automatic logic [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 32'd0;
        if (r < 20) return 32'($urandom_range(1, 8));
        if (r < 25) return 32'hFFFF_FFFF;
        if (r < 30) return 32'h8000_0000 | 32'($urandom_range(7));
        return $urandom;
    endfunction

    task automatic queue_random_op();
        int unsigned r;
        logic [1:0]  cmd;
        r = $urandom_range(99);
        if (r < 45)      cmd = CMD_TICK;
        else if (r < 70) cmd = CMD_WRITE;
        else if (r < 97) cmd = CMD_READ;
        else             cmd = CMD_UNDEF;
        queue_op(cmd, pick_spr(), pick_value());
    endtask

    task automatic run_random_phase(int n_ops, int send_pct, int stall_pct_v,
                                    logic [31:0] pvr, logic [4:0] div, logic [3:0] pll);
        int start;
        int chunk;
        int r;
        set_config(pvr, div, pll);
        send_idle_pct = send_pct;
        stall_pct = stall_pct_v;
        start = ops_queued;
        chunk = 0;
        while (ops_queued - start < n_ops) begin
            r = $urandom_range(99);
            if (r < 3)      queue_dec_run();
            else if (r < 5) queue_tb_carry();
            else            queue_random_op();
            // drain completely every so often so the unit sees a cold restart
            if ((ops_queued - start) / 60 != chunk) begin
                chunk = (ops_queued - start) / 60;
                wait_drained();
            end
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < 1024; i++) plain_regs[i] = 32'd0;
        time_base = '0;
        tb_phase = 0;
        dec_count = '0;
        dec_phase = 0;
        pvr_value = '0;
        dec_div = DEC_DIV_RESET;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: PVR and HID1 clear, divider of two wraps DEC on the 2nd tick
        queue_op(CMD_READ, SPR_PVR, $urandom);
        queue_op(CMD_READ, SPR_HID1, $urandom);
        queue_op(CMD_TICK, SPR_NONE, 32'd0);
        queue_op(CMD_TICK, SPR_NONE, 32'd0);
        queue_op(CMD_READ, SPR_DEC, 32'd0);

        set_config(32'hFFFF_FFFF, 5'd1, 4'hF);
        queue_op(CMD_READ, SPR_PVR, 32'd0);
        queue_op(CMD_READ, SPR_HID1, 32'd0);
        queue_op(CMD_WRITE, SPR_LR, 32'hFFFF_FFFF);
        queue_op(CMD_READ, SPR_LR, 32'd0);
        queue_op(CMD_WRITE, SPR_SCR3, 32'h0000_0000);
        queue_op(CMD_READ, SPR_SCR3, 32'hFFFF_FFFF);
        // decrementer: zero write, fresh sign bit, sign already set, then a wrap
        queue_op(CMD_WRITE, SPR_DEC, 32'd0);
        queue_op(CMD_WRITE, SPR_DEC, 32'h8000_0000);
        queue_op(CMD_WRITE, SPR_DEC, 32'hFFFF_FFFF);
        queue_op(CMD_WRITE, SPR_DEC, 32'd1);
        queue_op(CMD_TICK, SPR_NONE, 32'd0);
        queue_op(CMD_TICK, SPR_NONE, 32'd0);
        queue_op(CMD_READ, SPR_DEC, 32'd0);
        // timebase halves through the read numbers, carry across the halves
        queue_op(CMD_WRITE, SPR_TBL_R, 32'hFFFF_FFFF);
        queue_op(CMD_WRITE, SPR_TBU_R, 32'h7FFF_FFFF);
        repeat (TB_TICKS) queue_op(CMD_TICK, SPR_NONE, 32'd0);
        queue_op(CMD_READ, SPR_TBL_W, 32'd0);
        queue_op(CMD_READ, SPR_TBU_W, 32'd0);
        queue_op(CMD_READ, SPR_TBL_R, 32'd0);
        queue_op(CMD_READ, SPR_TBU_R, 32'd0);
        // ignored PVR write, unknown numbers, undefined command
        queue_op(CMD_WRITE, SPR_PVR, 32'h1234_5678);
        queue_op(CMD_READ, SPR_NONE, 32'd0);
        queue_op(CMD_WRITE, 10'h3FF, 32'hFFFF_FFFF);
        queue_op(CMD_UNDEF, SPR_DEC, 32'hFFFF_FFFF);
        wait_drained();

        run_random_phase(250, 0, 0, $urandom, 5'd31, 4'h0);
        run_random_phase(250, 84, 0, 32'd0, 5'd2, 4'($urandom));
        run_random_phase(250, 0, 84, $urandom, 5'd0, 4'($urandom));
        run_random_phase(280, 10, 10, $urandom, 5'($urandom_range(1, 31)), 4'($urandom));

        for (int c = 0; c < 20000 && results_seen < ops_queued; c++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 32'd0,
                            32'(expected_results.size()));
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
